>>> rtl/clti_pkg.sv
// Shared types and constants for the clamped linear table interpolator.
package clti_pkg;
   localparam int TableDepth = 64;
   localparam int ValueWidth = 32;
   localparam int IndexWidth = $clog2(TableDepth);
   localparam int CountWidth = 7;
   localparam int DivWidth   = 2 * ValueWidth;
   localparam int DivCntWidth = $clog2(DivWidth + 1);

   localparam logic [1:0] FlagInside = 2'd0;
   localparam logic [1:0] FlagBelow  = 2'd1;
   localparam logic [1:0] FlagAbove  = 2'd2;

   localparam logic ModeLoad  = 1'b0;
   localparam logic ModeQuery = 1'b1;

   typedef struct packed {
      logic load_write;
      logic query_load;
      logic addr_sel_scan;
      logic [IndexWidth-1:0] rd_addr;
      logic cap_first;
      logic cap_last;
      logic cap_cur;
      logic cap_prev;
      logic mul_start;
      logic div_step;
      logic finish;
   } ctrl_type;

   typedef struct packed {
      logic below;
      logic above;
      logic cur_ge;
      logic equal_pair;
   } status_type;
endpackage

>>> rtl/clti_ram.sv
// Generic single-port-write, registered-read RAM.
module clti_ram #(
   parameter int Width = 32,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

>>> rtl/clti_datapath.sv
// Table storage, search compare, and multiply-divide datapath.
module clti_datapath
   import clti_pkg::*;
(
   input  logic                         clock,
   input  ctrl_type                     ctrl,
   input  logic [IndexWidth-1:0]        load_index,
   input  logic signed [ValueWidth-1:0] x_in,
   input  logic signed [ValueWidth-1:0] y_in,
   output status_type                   status,
   output logic signed [ValueWidth-1:0] y_result
);
   logic signed [ValueWidth-1:0] rd_x, rd_y;
   logic signed [ValueWidth-1:0] qx_ff, x0_ff, y0_ff, xl_ff, yl_ff;
   logic signed [ValueWidth-1:0] xc_ff, yc_ff, xp_ff, yp_ff;
   logic [DivWidth-1:0] quo_ff;
   logic [ValueWidth:0] rem_ff, rem_sh;
   logic [ValueWidth-1:0] x_off, dx, dy, div_ff;
   logic neg_ff, ge;
   logic signed [ValueWidth-1:0] y_ff;

   clti_ram #(.Width(ValueWidth), .Depth(TableDepth)) u_ram_x (
      .clock(clock), .wr_en(ctrl.load_write), .wr_addr(load_index), .wr_data(x_in),
      .rd_addr(ctrl.rd_addr), .rd_data(rd_x));
   clti_ram #(.Width(ValueWidth), .Depth(TableDepth)) u_ram_y (
      .clock(clock), .wr_en(ctrl.load_write), .wr_addr(load_index), .wr_data(y_in),
      .rd_addr(ctrl.rd_addr), .rd_data(rd_y));

   assign x_off  = qx_ff - xp_ff;
   assign dx     = xc_ff - xp_ff;
   assign ge     = (yc_ff >= yp_ff);
   assign dy     = ge ? yc_ff - yp_ff : yp_ff - yc_ff;
   assign rem_sh = {rem_ff[ValueWidth-1:0], quo_ff[DivWidth-1]};

   always_ff @(posedge clock) begin
      if (ctrl.query_load) begin
         qx_ff <= x_in;
      end
      if (ctrl.cap_first) begin
         x0_ff <= rd_x;
         y0_ff <= rd_y;
      end
      if (ctrl.cap_last) begin
         xl_ff <= rd_x;
         yl_ff <= rd_y;
      end
      if (ctrl.cap_cur) begin
         xp_ff <= xc_ff;
         yp_ff <= yc_ff;
         xc_ff <= rd_x;
         yc_ff <= rd_y;
      end
      if (ctrl.mul_start) begin
         quo_ff <= DivWidth'(x_off) * DivWidth'(dy);
         rem_ff <= '0;
         div_ff <= dx;
         neg_ff <= ~ge;
      end
      if (ctrl.div_step) begin
         if (rem_sh >= {1'b0, div_ff}) begin
            rem_ff <= rem_sh - {1'b0, div_ff};
            quo_ff <= {quo_ff[DivWidth-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            quo_ff <= {quo_ff[DivWidth-2:0], 1'b0};
         end
      end
      if (ctrl.finish) begin
         if (status.below) begin
            y_ff <= y0_ff;
         end else if (status.above) begin
            y_ff <= yl_ff;
         end else if (status.equal_pair) begin
            y_ff <= yc_ff;
         end else if (neg_ff) begin
            y_ff <= yp_ff - quo_ff[ValueWidth-1:0];
         end else begin
            y_ff <= yp_ff + quo_ff[ValueWidth-1:0];
         end
      end
   end

   assign status.below      = qx_ff < x0_ff;
   assign status.above      = xl_ff < qx_ff;
   assign status.cur_ge     = !(rd_x < qx_ff);
   assign status.equal_pair = (xc_ff == xp_ff) | ctrl.cap_prev;
   assign y_result = y_ff;
endmodule

>>> rtl/clti_ctrl.sv
// Sequencing state machine: load, edge reads, linear scan, divide.
module clti_ctrl
   import clti_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  mode,
   input  logic [CountWidth-1:0] point_count,
   input  status_type            status,
   output ctrl_type              ctrl,
   output logic                  busy,
   output logic                  done,
   output logic [1:0]            flag
);
   typedef enum logic [3:0] {
      IDLE, RD_FIRST, RD_LAST, CHECK, SCAN, MUL, DIVIDE, FINISH, EMIT
   } state_type;

   state_type state_ff;
   logic [IndexWidth:0] n_ff, k_ff;
   logic [DivCntWidth-1:0] cnt_ff;
   logic first_hit_ff, done_ff;
   logic [1:0] flag_ff;
   logic [IndexWidth:0] n_clip;

   always_comb begin
      if (point_count < 7'd2) begin
         n_clip = (IndexWidth+1)'(2);
      end else if (32'(point_count) > TableDepth) begin
         n_clip = (IndexWidth+1)'(TableDepth);
      end else begin
         n_clip = (IndexWidth+1)'(point_count);
      end
   end

   always_comb begin
      ctrl = '0;
      ctrl.load_write = (state_ff == IDLE) && start && (mode == ModeLoad);
      ctrl.query_load = (state_ff == IDLE) && start && (mode == ModeQuery);
      case (state_ff)
         IDLE:     ctrl.rd_addr = '0;
         RD_FIRST: begin
            ctrl.rd_addr   = IndexWidth'(n_ff - 1'b1);
            ctrl.cap_first = 1'b1;
         end
         RD_LAST:  begin
            ctrl.cap_last = 1'b1;
            ctrl.rd_addr  = '0;
         end
         CHECK:    ctrl.rd_addr = '0;
         SCAN:     begin
            ctrl.rd_addr = IndexWidth'(k_ff + 1'b1);
            ctrl.cap_cur = 1'b1;
         end
         MUL:      ctrl.mul_start = 1'b1;
         DIVIDE:   ctrl.div_step = 1'b1;
         FINISH:   begin
            ctrl.finish   = 1'b1;
            ctrl.cap_prev = first_hit_ff;
         end
         default:  ctrl.rd_addr = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         n_ff         <= '0;
         k_ff         <= '0;
         cnt_ff       <= '0;
         first_hit_ff <= 1'b0;
         done_ff      <= 1'b0;
         flag_ff      <= FlagInside;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            IDLE: begin
               if (start && mode == ModeQuery) begin
                  n_ff     <= n_clip;
                  state_ff <= RD_FIRST;
               end
            end
            RD_FIRST: state_ff <= RD_LAST;
            RD_LAST:  state_ff <= CHECK;
            CHECK: begin
               k_ff         <= '0;
               first_hit_ff <= 1'b0;
               if (status.below) begin
                  flag_ff  <= FlagBelow;
                  state_ff <= FINISH;
               end else if (status.above) begin
                  flag_ff  <= FlagAbove;
                  state_ff <= FINISH;
               end else begin
                  flag_ff  <= FlagInside;
                  state_ff <= SCAN;
               end
            end
            SCAN: begin
               if (status.cur_ge || k_ff == n_ff - 1'b1) begin
                  if (k_ff == '0) begin
                     first_hit_ff <= 1'b1;
                     state_ff     <= FINISH;
                  end else begin
                     state_ff <= MUL;
                  end
               end else begin
                  k_ff <= k_ff + 1'b1;
               end
            end
            MUL: begin
               cnt_ff   <= '0;
               state_ff <= DIVIDE;
            end
            DIVIDE: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == DivCntWidth'(DivWidth - 1)) begin
                  state_ff <= FINISH;
               end
            end
            FINISH: state_ff <= EMIT;
            EMIT: begin
               done_ff  <= 1'b1;
               state_ff <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign busy = (state_ff != IDLE);
   assign done = done_ff;
   assign flag = flag_ff;

`ifndef NO_ASSERTIONS
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done |-> state_ff == IDLE) else $error("strobe outside idle");
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == SCAN |-> k_ff < n_ff) else $error("scan past table");
   a_div_len: assert property (@(posedge clock) disable iff (reset)
      state_ff == DIVIDE |-> 32'(cnt_ff) < DivWidth) else $error("divide overrun");
`endif
endmodule

>>> rtl/clamped_linear_table_interp_top.sv
// Top level of the clamped piecewise-linear table interpolator.
// A load transaction writes one breakpoint and never raises busy, so loads can
// follow back to back. A query transaction holds busy while it reads the
// table ends, runs a linear scan that reads one entry a cycle up to the first
// breakpoint at or above x, forms the product, runs a bit-serial divider that
// retires one of 64 quotient bits a cycle, and picks and registers the result.
// A query clamped below or above skips the scan, multiply and divide, and one
// equal to the first breakpoint skips the multiply and divide. The result
// appears for one cycle with rsp_valid, in the first cycle in which busy is low,
// in which the next transaction can already be accepted; it cannot stall.
module clamped_linear_table_interp_top
   import clti_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_mode,
   input  logic [IndexWidth-1:0]        req_entry_index,
   input  logic signed [ValueWidth-1:0] req_x_value,
   input  logic signed [ValueWidth-1:0] req_y_value,
   output logic                         rsp_valid,
   output logic signed [ValueWidth-1:0] rsp_y_result,
   output logic [1:0]                   rsp_range_flag,
   input  logic                         csr_write,
   input  logic [CountWidth-1:0]        csr_wdata
);
   logic [CountWidth-1:0] point_count_ff;
   ctrl_type   ctrl;
   status_type status;

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= CountWidth'(64);
      end else if (csr_write) begin
         point_count_ff <= csr_wdata;
      end
   end

   clti_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .mode(req_mode),
      .point_count(point_count_ff),
      .status(status), .ctrl(ctrl), .busy(busy), .done(rsp_valid),
      .flag(rsp_range_flag));

   clti_datapath u_dp (
      .clock(clock), .ctrl(ctrl), .load_index(req_entry_index),
      .x_in(req_x_value), .y_in(req_y_value), .status(status),
      .y_result(rsp_y_result));
endmodule

>>> test/clamped_linear_table_interp_top_tb.sv
// Self-checking testbench for the clamped piecewise-linear table interpolator.
module clamped_linear_table_interp_top_tb
   import clti_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic signed [ValueWidth-1:0] value_type;

   typedef struct {
      value_type  y;
      logic [1:0] flag;
   } interp_result_type;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic                  req_mode;
   logic [IndexWidth-1:0] req_entry_index;
   value_type             req_x_value;
   value_type             req_y_value;
   logic                  rsp_valid;
   value_type             rsp_y_result;
   logic [1:0]            rsp_range_flag;
   logic                  csr_write;
   logic [CountWidth-1:0] csr_wdata;

   value_type         table_x [TableDepth];
   value_type         table_y [TableDepth];
   logic [CountWidth-1:0] active_count;
   interp_result_type pending_results[$];
   int             idle_pct;
   int             error_count;
   int             query_count;
   int             load_count;
   int             config_count;

   clamped_linear_table_interp_top DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_mode(req_mode),
      .req_entry_index(req_entry_index),
      .req_x_value(req_x_value),
      .req_y_value(req_y_value),
      .rsp_valid(rsp_valid),
      .rsp_y_result(rsp_y_result),
      .rsp_range_flag(rsp_range_flag),
      .csr_write(csr_write),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("Some tests failed");
      $finish;
   end

   function automatic int points_in_use();
      int n;
      n = int'(active_count);
      if (n < 2) n = 2;
      if (n > TableDepth) n = TableDepth;
      return n;
   endfunction

   function automatic interp_result_type interpolate(input value_type x);
      interp_result_type r;
      int             n;
      int             i;
      longint         x_off;
      longint         dx;
      longint         dy;
      logic [127:0]   prod;
      logic [127:0]   quot;
      n = points_in_use();
      r.flag = FlagInside;
      if (x < table_x[0]) begin
         r.y = table_y[0];
         r.flag = FlagBelow;
      end else if (x > table_x[n-1]) begin
         r.y = table_y[n-1];
         r.flag = FlagAbove;
      end else begin
         i = n - 1;
         for (int k = n - 1; k >= 0; k--)
            if (table_x[k] >= x) i = k;
         if (i == 0 || table_x[i] == table_x[i-1]) begin
            r.y = table_y[i];
         end else begin
            x_off = longint'(x) - longint'(table_x[i-1]);
            dx = longint'(table_x[i]) - longint'(table_x[i-1]);
            if (table_y[i] >= table_y[i-1]) dy = longint'(table_y[i]) - longint'(table_y[i-1]);
            else dy = longint'(table_y[i-1]) - longint'(table_y[i]);
            prod = {64'd0, 64'(x_off)} * {64'd0, 64'(dy)};
            quot = prod / {64'd0, 64'(dx)};
            if (table_y[i] >= table_y[i-1]) r.y = table_y[i-1] + quot[ValueWidth-1:0];
            else r.y = table_y[i-1] - quot[ValueWidth-1:0];
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      interp_result_type e;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result y=%h flag=%0d", $time, rsp_y_result,
                     rsp_range_flag);
            error_count++;
         end else begin
            e = pending_results.pop_front();
            if (rsp_y_result !== e.y) begin
               $display("%0t: y_result expected %h actual %h", $time, e.y, rsp_y_result);
               error_count++;
            end
            if (rsp_range_flag !== e.flag) begin
               $display("%0t: range_flag expected %0d actual %0d", $time, e.flag,
                        rsp_range_flag);
               error_count++;
            end
         end
      end
   end

   // hold the transaction until accepted, then idle at random
   task automatic send_item(input logic m, input logic [IndexWidth-1:0] idx,
                            input value_type xv, input value_type yv);
      int gap;
      start <= 1'b1;
      req_mode <= m;
      req_entry_index <= idx;
      req_x_value <= xv;
      req_y_value <= yv;
      @(negedge clock);
      while (busy) @(negedge clock);
      @(posedge clock);
      if (m == ModeQuery) begin
         pending_results = {pending_results, interpolate(xv)};
         query_count++;
      end else begin
         table_x[idx] = xv;
         table_y[idx] = yv;
         load_count++;
      end
      if ($urandom_range(99) < idle_pct) begin
         gap = $urandom_range(1, 4);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic query(input value_type xv);
      send_item(ModeQuery, IndexWidth'($urandom), xv, value_type'($urandom));
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_results.size() != 0 || busy) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic write_count(input logic [CountWidth-1:0] v);
      drain();
      csr_write <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_write <= 1'b0;
      active_count = v;
      config_count++;
      @(posedge clock);
   endtask

   // shape: 0 spread ascending, 1 ascending with repeats, 2 unordered, 3 tight steps
   task automatic load_table(input int shape);
      int     vals[$];
      longint acc;
      vals = {};
      acc = longint'($urandom_range(0, 32'h7fff_ffff)) - 64'h4000_0000;
      for (int k = 0; k < TableDepth; k++) begin
         if (shape == 3) begin
            acc += $urandom_range(0, 3);
            vals = {vals, int'(acc)};
         end else begin
            vals = {vals, int'($urandom)};
         end
      end
      if (shape == 0 || shape == 1) vals.sort();
      if (shape == 1)
         for (int k = 1; k < TableDepth; k++)
            if ($urandom_range(4) == 0) vals[k] = vals[k-1];
      for (int k = 0; k < TableDepth; k++)
         send_item(ModeLoad, IndexWidth'(k), value_type'(vals[k]), value_type'($urandom));
   endtask

   function automatic value_type pick_query_x();
      int          n;
      int          k;
      longint      lo;
      longint      span;
      n = points_in_use();
      k = $urandom_range(1, n - 1);
      case ($urandom_range(7))
         0: return value_type'($urandom);
         1: return table_x[$urandom_range(0, n - 1)];
         2: return (table_x[0] == 32'sh8000_0000) ? table_x[0] : table_x[0] - 1;
         3: return (table_x[n-1] == 32'sh7fff_ffff) ? table_x[n-1] : table_x[n-1] + 1;
         4: return $urandom_range(1) ? 32'sh8000_0000 : 32'sh7fff_ffff;
         default: begin
            lo = table_x[k-1];
            span = longint'(table_x[k]) - lo;
            if (span <= 0) return table_x[k];
            return value_type'(lo + longint'({$urandom, $urandom} % (64'(span) + 1)));
         end
      endcase
   endfunction

   task automatic test_directed();
      value_type y_set [TableDepth];
      idle_pct = 0;
      for (int k = 0; k < TableDepth; k++) y_set[k] = value_type'($urandom);
      y_set[0] = 32'sh8000_0000;
      y_set[TableDepth-1] = 32'sh7fff_ffff;
      y_set[20] = 32'sh7fff_ffff;
      y_set[21] = 32'sh8000_0000;
      for (int k = 0; k < TableDepth; k++)
         send_item(ModeLoad, IndexWidth'(k),
                   (k == 11) ? value_type'((10 - 32) <<< 24) : value_type'((k - 32) <<< 24),
                   y_set[k]);
      query(32'sh8000_0000);
      query(32'sh7fff_ffff);
      query(table_x[0]);
      query(table_x[TableDepth-1]);
      query(table_x[0] - 1);
      query(table_x[TableDepth-1] + 1);
      query(table_x[10]);
      query(table_x[11] + 1);
      query(table_x[5]);
      query(table_x[5] + 1);
      query(table_x[6] - 1);
      query(table_x[20] + (1 <<< 23));
      query(table_x[21] - 3);
      query(32'sh0000_0000);
      query(32'sh0000_8000);
      drain();
   endtask

   task automatic test_random();
      int counts [9] = '{64, 2, 0, 3, 1, 127, 65, 17, 33};
      int idles [3] = '{0, 72, 6};
      for (int p = 0; p < 9; p++) begin
         write_count(CountWidth'(counts[p]));
         idle_pct = idles[p % 3];
         load_table(p % 4);
         for (int q = 0; q < 150; q++) begin
            if ($urandom_range(99) == 0) drain();
            if ($urandom_range(9) == 0)
               send_item(ModeLoad, IndexWidth'($urandom), value_type'($urandom),
                         value_type'($urandom));
            else
               query(pick_query_x());
         end
      end
      write_count(CountWidth'(64));
      idle_pct = 72;
      for (int q = 0; q < 20; q++) query(pick_query_x());
      drain();
   endtask

   initial begin
      error_count = 0;
      query_count = 0;
      load_count = 0;
      config_count = 0;
      idle_pct = 0;
      active_count = CountWidth'(TableDepth);
      for (int k = 0; k < TableDepth; k++) begin
         table_x[k] = '0;
         table_y[k] = '0;
      end
      reset <= 1'b1;
      start <= 1'b0;
      req_mode <= ModeLoad;
      req_entry_index <= '0;
      req_x_value <= '0;
      req_y_value <= '0;
      csr_write <= 1'b0;
      csr_wdata <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random();
      $display("Ran %0d queries and %0d table loads over %0d point-count settings,",
               query_count, load_count, config_count);
      $display("with ascending, repeated, unordered and tight tables and random idling.");
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
